### design/elog_pkg.sv
// shared types and codes for the event log ring with state search
// no dependencies; used by every module of the block but elog_step
`timescale 1ns / 1ps

package elog_pkg;

  // request modes
  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_REWIND = 3'd2;
  localparam logic [2:0] MODE_SEARCH = 3'd3;
  localparam logic [2:0] MODE_CHANGE = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // one result item
  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] slot_index;
    logic [7:0]  stored_state;
    logic [11:0] steps_done;
  } res_t;

  // state memory access, one per cycle
  typedef struct packed {
    logic        wr_en;
    logic [11:0] addr;
    logic [7:0]  wr_data;
  } mem_req_t;

endpackage

### design/event_log_ring_with_state_search.sv
// top level of the event log ring with state search
// depends on elog_pkg, elog_ctrl, elog_step and elog_mem
`timescale 1ns / 1ps

// Usage
// One request enters on the in_ channel (valid/ready) and gives exactly one
// result on the out_ channel (valid/ready). in_ready is high only while the
// sequencer is idle; it rises again once the result has moved into the output
// register, so a new request may be taken while that result waits.
// A rewind steps the read pointer back one entry at a time from the newest entry;
// a search spends a memory read state and then a compare state on each entry it
// walks, as both go through the single state memory port.
// With the receiver ready, a new request is taken at the edge where the result
// of the one before it leaves, so the sequencer works on one request at a time.
// Reset clears the three pointers and the output valid; the state bytes are
// not cleared and need no sweep. When the receiver stalls, the result holds
// in the output register and the block takes at most one further request,
// which then waits finished inside the sequencer.

module event_log_ring_with_state_search #(
  parameter int RING_BASE = 0,
  parameter int RING_END  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_state_value,
  input  logic [11:0] in_entry_index,
  input  logic [11:0] in_back_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [11:0] out_slot_index,
  output logic [7:0]  out_stored_state,
  output logic [11:0] out_steps_done
);

  elog_pkg::res_t     res;
  elog_pkg::res_t     out_r;
  elog_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rd_data;
  logic               res_valid;
  logic               res_take;
  logic               out_valid_r;

  elog_ctrl #(
    .RING_BASE (RING_BASE),
    .RING_END  (RING_END)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_state_value (in_state_value),
    .in_entry_index (in_entry_index),
    .in_back_count  (in_back_count),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res            (res),
    .mem_req        (mem_req),
    .mem_rd_data    (mem_rd_data)
  );

  elog_mem #(
    .DEPTH (RING_END)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  // output register, loads when empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_slot_index   = out_r.slot_index;
  assign out_stored_state = out_r.stored_state;
  assign out_steps_done   = out_r.steps_done;

endmodule

### design/elog_mem.sv
// state byte store of the event log, one write or one read per cycle
// depends on elog_pkg for the access request struct
`timescale 1ns / 1ps

module elog_mem #(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  elog_pkg::mem_req_t req,
  output logic [7:0]         rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.addr[AW-1:0]] <= req.wr_data;
    end
    rd_data_r <= mem_r[req.addr[AW-1:0]];
  end

  assign rd_data = rd_data_r;

endmodule

### design/elog_step.sv
// shared ring pointer step unit: one wrapped increment or decrement
// no package dependency; bounds come from the top level parameters
`timescale 1ns / 1ps

module elog_step #(
  parameter int RING_BASE = 0,
  parameter int RING_END  = 1024
) (
  input  logic [11:0] ptr,
  input  logic        step_back,
  output logic [11:0] ptr_step
);

  localparam logic [11:0] BASE_C = 12'(RING_BASE);
  localparam logic [11:0] LAST_C = 12'(RING_END - 1);
  localparam logic [12:0] END_C  = 13'(RING_END);

  logic [12:0] inc;

  assign inc = {1'b0, ptr} + 13'd1;

  // forward wraps at the end, backward wraps below the base
  always_comb begin
    if (step_back) begin
      ptr_step = (ptr <= BASE_C) ? LAST_C : ptr - 12'd1;
    end else begin
      ptr_step = (inc >= END_C) ? BASE_C : inc[11:0];
    end
  end

endmodule

### design/elog_ctrl.sv
// sequencer of the event log: pointers, request decode, rewind and search walks
// depends on elog_pkg, elog_step (shared pointer step) and the state memory port
`timescale 1ns / 1ps

module elog_ctrl #(
  parameter int RING_BASE = 0,
  parameter int RING_END  = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [7:0]         in_state_value,
  input  logic [11:0]        in_entry_index,
  input  logic [11:0]        in_back_count,
  output logic               res_valid,
  input  logic               res_take,
  output elog_pkg::res_t     res,
  output elog_pkg::mem_req_t mem_req,
  input  logic [7:0]         mem_rd_data
);

  localparam logic [11:0] BASE_C = 12'(RING_BASE);
  localparam logic [12:0] END_C  = 13'(RING_END);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXEC     = 7'b0000010,
    S_APP_FIX  = 7'b0000100,
    S_RD_WAIT  = 7'b0001000,
    S_RWD      = 7'b0010000,
    S_SRCH_RD  = 7'b0100000,
    S_SRCH_CMP = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;

  logic [11:0] wp_r, wp_nxt;
  logic [11:0] rp_r, rp_nxt;
  logic [11:0] op_r, op_nxt;
  logic [11:0] scan_r, scan_nxt;
  logic [11:0] cnt_r, cnt_nxt;

  logic [2:0]  mode_r;
  logic [7:0]  val_r;
  logic [11:0] idx_r;
  logic [11:0] back_r;

  elog_pkg::res_t res_r, res_nxt;

  logic [11:0] step_in;
  logic        step_back;
  logic [11:0] step_out;
  logic        accept;
  logic        idx_bad;

  elog_step #(
    .RING_BASE (RING_BASE),
    .RING_END  (RING_END)
  ) u_step (
    .ptr       (step_in),
    .step_back (step_back),
    .ptr_step  (step_out)
  );

  assign in_ready  = (state_r == S_IDLE) && !fin_r;
  assign accept    = in_valid && in_ready;
  assign res_valid = fin_r;
  assign res       = res_r;
  assign idx_bad   = (idx_r < BASE_C) || ({1'b0, idx_r} >= END_C);

  // sequencer next state and datapath
  always_comb begin
    state_nxt         = state_r;
    fin_nxt           = fin_r;
    wp_nxt            = wp_r;
    rp_nxt            = rp_r;
    op_nxt            = op_r;
    scan_nxt          = scan_r;
    cnt_nxt           = cnt_r;
    res_nxt           = res_r;
    step_in           = wp_r;
    step_back         = 1'b0;
    mem_req.wr_en     = 1'b0;
    mem_req.addr      = rp_r;
    mem_req.wr_data   = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (fin_r && res_take) begin
          fin_nxt = 1'b0;
        end
        if (accept) begin
          res_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        fin_nxt   = 1'b1;
        unique case (mode_r)
          elog_pkg::MODE_APPEND: begin
            mem_req.wr_en        = 1'b1;
            mem_req.addr         = wp_r;
            res_nxt.slot_index   = wp_r;
            res_nxt.stored_state = val_r;
            wp_nxt               = step_out;
            fin_nxt              = 1'b0;
            state_nxt            = S_APP_FIX;
          end
          elog_pkg::MODE_READ: begin
            if (rp_r == wp_r) begin
              res_nxt.status = elog_pkg::ST_MISS;
            end else begin
              step_in            = rp_r;
              rp_nxt             = step_out;
              res_nxt.slot_index = rp_r;
              fin_nxt            = 1'b0;
              state_nxt          = S_RD_WAIT;
            end
          end
          elog_pkg::MODE_REWIND: begin
            if (op_r == wp_r) begin
              res_nxt.status = elog_pkg::ST_MISS;
            end else begin
              step_back = 1'b1;
              rp_nxt    = step_out;
              cnt_nxt   = 12'd1;
              fin_nxt   = 1'b0;
              state_nxt = S_RWD;
            end
          end
          elog_pkg::MODE_SEARCH: begin
            res_nxt.status = elog_pkg::ST_MISS;
            scan_nxt       = op_r;
            fin_nxt        = 1'b0;
            state_nxt      = S_SRCH_RD;
          end
          elog_pkg::MODE_CHANGE: begin
            if (idx_bad) begin
              res_nxt.status = elog_pkg::ST_RANGE;
            end else begin
              mem_req.wr_en        = 1'b1;
              mem_req.addr         = idx_r;
              res_nxt.slot_index   = idx_r;
              res_nxt.stored_state = val_r;
            end
          end
          elog_pkg::MODE_CLEAR: begin
            wp_nxt = BASE_C;
            rp_nxt = BASE_C;
            op_nxt = BASE_C;
          end
          default: begin
          end
        endcase
      end

      // drop the oldest entry when the write pointer caught up with it
      S_APP_FIX: begin
        if (wp_r == op_r) begin
          step_in = op_r;
          op_nxt  = step_out;
        end
        fin_nxt   = 1'b1;
        state_nxt = S_IDLE;
      end

      S_RD_WAIT: begin
        res_nxt.stored_state = mem_rd_data;
        fin_nxt              = 1'b1;
        state_nxt            = S_IDLE;
      end

      // step the read pointer back one entry a cycle
      S_RWD: begin
        if ((cnt_r < back_r) && (rp_r != op_r)) begin
          step_in   = rp_r;
          step_back = 1'b1;
          rp_nxt    = step_out;
          cnt_nxt   = cnt_r + 12'd1;
        end else begin
          res_nxt.steps_done = cnt_r;
          res_nxt.slot_index = rp_r;
          fin_nxt            = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      // search walk: issue the read, then compare the returned byte
      S_SRCH_RD: begin
        mem_req.addr = scan_r;
        if (scan_r == wp_r) begin
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end

      S_SRCH_CMP: begin
        if (mem_rd_data == val_r) begin
          res_nxt.status       = elog_pkg::ST_OK;
          res_nxt.slot_index   = scan_r;
          res_nxt.stored_state = val_r;
          fin_nxt              = 1'b1;
          state_nxt            = S_IDLE;
        end else begin
          step_in   = scan_r;
          scan_nxt  = step_out;
          state_nxt = S_SRCH_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
      wp_r    <= BASE_C;
      rp_r    <= BASE_C;
      op_r    <= BASE_C;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      op_r    <= op_nxt;
    end
  end

  // request fields and work registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      val_r  <= in_state_value;
      idx_r  <= in_entry_index;
      back_r <= in_back_count;
    end
    scan_r <= scan_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

endmodule

### design/elog_chk.sv
// port level checks for the event log ring with state search
// depends on elog_pkg status codes; bound to the top level below
`timescale 1ns / 1ps

module elog_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [11:0] out_slot_index,
  input logic [7:0]  out_stored_state,
  input logic [11:0] out_steps_done
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot_index)
      && $stable(out_status) && $stable(out_stored_state) && $stable(out_steps_done))
    else $error("stalled result changed");

  // in_ready is low in the cycle after a request is accepted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  // rewind step count only comes with an ok status
  a_steps_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_steps_done != 12'd0) |-> out_status == elog_pkg::ST_OK)
    else $error("steps reported on failed request");

  // a miss carries no slot and no state byte
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == elog_pkg::ST_MISS)
      |-> (out_slot_index == 12'd0) && (out_stored_state == 8'd0))
    else $error("miss result with nonzero fields");

  // status never takes the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == elog_pkg::ST_OK) || (out_status == elog_pkg::ST_MISS)
      || (out_status == elog_pkg::ST_RANGE))
    else $error("unused status code");

endmodule

bind event_log_ring_with_state_search elog_chk u_elog_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_slot_index   (out_slot_index),
  .out_stored_state (out_stored_state),
  .out_steps_done   (out_steps_done)
);

### verif/tb_event_log_ring_with_state_search.sv
`timescale 1ns / 1ps
// self-checking bench for event_log_ring_with_state_search: directed and random log
// requests checked against a cycle-free shadow of the ring; needs elog_pkg and the design

module tb_event_log_ring_with_state_search;

  localparam int RING_BASE = 0;
  localparam int RING_END  = 1024;
  localparam int RING_SIZE = RING_END - RING_BASE;

  // modes the block must answer with an all-zero ok result
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  // no-idle windows, counted in requests on each side
  localparam int CALM_FIRST = 500;
  localparam int CALM_LAST  = 800;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  state_value;
    logic [11:0] entry_index;
    logic [11:0] back_count;
  } log_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode = '0;
  logic [7:0]  in_state_value = '0;
  logic [11:0] in_entry_index = '0;
  logic [11:0] in_back_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [11:0] out_slot_index;
  logic [7:0]  out_stored_state;
  logic [11:0] out_steps_done;

  // shadow of the ring
  int         wr_ptr = RING_BASE;
  int         rd_ptr = RING_BASE;
  int         old_ptr = RING_BASE;
  logic [7:0] slot_state [RING_BASE:RING_END-1];
  bit         slot_written [RING_BASE:RING_END-1];

  log_req_t       log_requests_q [$];
  elog_pkg::res_t log_answers_q [$];

  int mode_cnt [8];
  int wrap_cnt = 0;
  int err_cnt = 0;
  int n_sent = 0;
  int n_recv = 0;
  int cycle_cnt = 0;
  int cycle_budget = 0;
  int cycle_limit = 32'h7fffffff;

  event_log_ring_with_state_search #(
    .RING_BASE(RING_BASE),
    .RING_END (RING_END)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_state_value  (in_state_value),
    .in_entry_index  (in_entry_index),
    .in_back_count   (in_back_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_stored_state(out_stored_state),
    .out_steps_done  (out_steps_done)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int ring_next(int p);
    return (p + 1 >= RING_END) ? RING_BASE : p + 1;
  endfunction

  function automatic int ring_prev(int p);
    return (p <= RING_BASE) ? RING_END - 1 : p - 1;
  endfunction

  function automatic int live_entries();
    return (wr_ptr - old_ptr + RING_SIZE) % RING_SIZE;
  endfunction

  task automatic note_mismatch(input string msg);
    err_cnt++;
    $display("mismatch: %s", msg);
  endtask

  // one request applied to the shadow ring; cyc is a bound on the block's own cycle count
  task automatic ring_shadow_step(input log_req_t r, output elog_pkg::res_t res,
                                  output int cyc);
    int n;
    int p;
    int k;
    res = '0;
    cyc = 3;
    mode_cnt[r.mode]++;
    case (r.mode)
      elog_pkg::MODE_APPEND: begin
        slot_state[wr_ptr] = r.state_value;
        slot_written[wr_ptr] = 1'b1;
        res.slot_index = 12'(wr_ptr);
        res.stored_state = r.state_value;
        wr_ptr = ring_next(wr_ptr);
        if (wr_ptr == RING_BASE) wrap_cnt++;
        // full ring drops its oldest entry
        if (wr_ptr == old_ptr) old_ptr = ring_next(old_ptr);
        cyc = 4;
      end
      elog_pkg::MODE_READ: begin
        if (rd_ptr == wr_ptr) begin
          res.status = elog_pkg::ST_MISS;
        end else begin
          res.slot_index = 12'(rd_ptr);
          res.stored_state = slot_state[rd_ptr];
          rd_ptr = ring_next(rd_ptr);
          cyc = 4;
        end
      end
      elog_pkg::MODE_REWIND: begin
        if (old_ptr == wr_ptr) begin
          res.status = elog_pkg::ST_MISS;
        end else begin
          // start at the newest entry, then walk back toward the oldest
          n = 1;
          rd_ptr = ring_prev(wr_ptr);
          while (n < int'(r.back_count) && rd_ptr != old_ptr) begin
            rd_ptr = ring_prev(rd_ptr);
            n++;
          end
          res.steps_done = 12'(n);
          res.slot_index = 12'(rd_ptr);
          cyc = 3 + n;
        end
      end
      elog_pkg::MODE_SEARCH: begin
        // first match walking from oldest up to the write pointer
        res.status = elog_pkg::ST_MISS;
        p = old_ptr;
        k = 0;
        while (p != wr_ptr) begin
          k++;
          if (slot_state[p] == r.state_value) begin
            res.status = elog_pkg::ST_OK;
            res.slot_index = 12'(p);
            res.stored_state = r.state_value;
            break;
          end
          p = ring_next(p);
        end
        cyc = 4 + 2 * k;
      end
      elog_pkg::MODE_CHANGE: begin
        if (int'(r.entry_index) < RING_BASE || int'(r.entry_index) >= RING_END) begin
          res.status = elog_pkg::ST_RANGE;
        end else begin
          slot_state[r.entry_index] = r.state_value;
          slot_written[r.entry_index] = 1'b1;
          res.slot_index = r.entry_index;
          res.stored_state = r.state_value;
        end
      end
      elog_pkg::MODE_CLEAR: begin
        wr_ptr = RING_BASE;
        rd_ptr = RING_BASE;
        old_ptr = RING_BASE;
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_request(input logic [2:0] mode, input logic [7:0] val,
                               input logic [11:0] idx, input logic [11:0] back);
    log_req_t       r;
    elog_pkg::res_t res;
    int             cyc;
    // never let a read land on a slot with no state written yet
    if (mode == elog_pkg::MODE_READ && rd_ptr != wr_ptr && !slot_written[rd_ptr])
      mode = elog_pkg::MODE_APPEND;
    r.mode = mode;
    r.state_value = val;
    r.entry_index = idx;
    r.back_count = back;
    ring_shadow_step(r, res, cyc);
    log_requests_q.push_back(r);
    log_answers_q.push_back(res);
    cycle_budget += cyc + 40;
  endtask

  // random request with the given append and clear weights in percent
  task automatic queue_random(input int append_pct, input int clear_pct);
    int          pick;
    int          live;
    int          slot;
    logic [2:0]  mode;
    logic [7:0]  val;
    logic [11:0] idx;
    logic [11:0] back;
    live = live_entries();
    val = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < append_pct) begin
      mode = elog_pkg::MODE_APPEND;
    end else if (pick < append_pct + clear_pct) begin
      mode = elog_pkg::MODE_CLEAR;
    end else begin
      pick = $urandom_range(19);
      if (pick < 7) mode = elog_pkg::MODE_READ;
      else if (pick < 11) mode = elog_pkg::MODE_REWIND;
      else if (pick < 15) mode = elog_pkg::MODE_SEARCH;
      else if (pick < 19) mode = elog_pkg::MODE_CHANGE;
      else mode = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
    end
    // search keys taken from a live entry half of the time so hits are common
    if (mode == elog_pkg::MODE_SEARCH && live > 0 && $urandom_range(1) == 1) begin
      slot = (old_ptr - RING_BASE + int'($urandom_range(live - 1))) % RING_SIZE + RING_BASE;
      val = slot_state[slot];
    end
    pick = $urandom_range(19);
    if (pick < 16) idx = 12'($urandom_range(RING_END - 1, RING_BASE));
    else if (pick < 19) idx = 12'($urandom_range(4095, RING_END));
    else idx = 12'($urandom_range(4095));
    pick = $urandom_range(19);
    if (pick < 12) back = 12'($urandom_range(6));
    else if (pick < 16) back = 12'($urandom_range(live + 1, (live > 0) ? live - 1 : 0));
    else back = 12'($urandom_range(4095));
    queue_request(mode, val, idx, back);
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    log_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) n_sent++;
      if (!in_valid || in_ready) begin
        if (log_requests_q.size() > 0 &&
            ((n_sent >= CALM_FIRST && n_sent < CALM_LAST) || $urandom_range(99) >= 14)) begin
          nxt = log_requests_q.pop_front();
          in_valid <= 1'b1;
          in_mode <= nxt.mode;
          in_state_value <= nxt.state_value;
          in_entry_index <= nxt.entry_index;
          in_back_count <= nxt.back_count;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_results
    elog_pkg::res_t want;
    elog_pkg::res_t got;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_recv++;
        got = '{out_status, out_slot_index, out_stored_state, out_steps_done};
        if (log_answers_q.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with no request outstanding", n_recv));
        end else begin
          want = log_answers_q.pop_front();
          if (got !== want)
            note_mismatch($sformatf(
              "result %0d status %0d/%0d slot %0d/%0d state %0h/%0h steps %0d/%0d",
              n_recv, got.status, want.status, got.slot_index, want.slot_index,
              got.stored_state, want.stored_state, got.steps_done, want.steps_done));
        end
      end
      out_ready <= (n_recv >= CALM_FIRST && n_recv < CALM_LAST) || ($urandom_range(99) >= 14);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > cycle_limit) begin
      $display("timeout after %0d cycles, %0d requests still open", cycle_cnt,
               log_answers_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int start;

    // empty log corner cases and unused modes
    queue_request(elog_pkg::MODE_READ, 8'h00, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_REWIND, 8'hff, 12'hfff, 12'hfff);
    queue_request(elog_pkg::MODE_SEARCH, 8'h00, 12'h000, 12'h000);
    queue_request(MODE_SPARE_LO, 8'hff, 12'hfff, 12'hfff);
    queue_request(MODE_SPARE_HI, 8'h00, 12'h000, 12'h000);
    // change just past the end, far out, first slot and last slot
    queue_request(elog_pkg::MODE_CHANGE, 8'h5a, 12'(RING_END), 12'h000);
    queue_request(elog_pkg::MODE_CHANGE, 8'hff, 12'hfff, 12'hfff);
    queue_request(elog_pkg::MODE_CHANGE, 8'hff, 12'(RING_BASE), 12'h000);
    queue_request(elog_pkg::MODE_CHANGE, 8'h00, 12'(RING_END - 1), 12'h000);
    // a short log, then search hit and miss
    queue_request(elog_pkg::MODE_APPEND, 8'h00, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_APPEND, 8'hff, 12'hfff, 12'hfff);
    queue_request(elog_pkg::MODE_APPEND, 8'ha5, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_SEARCH, 8'hff, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_SEARCH, 8'h5a, 12'hfff, 12'hfff);
    // rewind of zero still steps once; a huge count stops at the oldest
    queue_request(elog_pkg::MODE_REWIND, 8'h00, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_REWIND, 8'h00, 12'h000, 12'hfff);
    queue_request(elog_pkg::MODE_READ, 8'h00, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_READ, 8'h00, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_READ, 8'h00, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_READ, 8'h00, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_REWIND, 8'h00, 12'h000, 12'h002);
    // clear keeps state bytes but empties the log
    queue_request(elog_pkg::MODE_CLEAR, 8'hff, 12'hfff, 12'hfff);
    queue_request(elog_pkg::MODE_READ, 8'h00, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_SEARCH, 8'hff, 12'h000, 12'h000);
    queue_request(elog_pkg::MODE_APPEND, 8'h3c, 12'h000, 12'h000);

    // short logs with frequent clears
    repeat (50) queue_random(40, 6);

    // fill past one full lap so the oldest entry gets dropped
    start = mode_cnt[elog_pkg::MODE_APPEND];
    while (mode_cnt[elog_pkg::MODE_APPEND] - start < RING_SIZE + 16) begin
      // rewind right after the write pointer wraps to the base
      if (wr_ptr == RING_BASE && live_entries() > 0)
        queue_request(elog_pkg::MODE_REWIND, 8'($urandom_range(255)),
                      12'($urandom_range(4095)), 12'($urandom_range(4)));
      queue_random(96, 0);
    end

    // work on a full, overwriting log, then with clears mixed in
    repeat (30) queue_random(30, 0);
    repeat (20) queue_random(40, 8);

    cycle_limit = 4 * cycle_budget + 10000;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (log_requests_q.size() != 0 || in_valid || log_answers_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("ran %0d requests: %0d append, %0d read, %0d rewind, %0d search, %0d change",
             n_sent, mode_cnt[elog_pkg::MODE_APPEND], mode_cnt[elog_pkg::MODE_READ],
             mode_cnt[elog_pkg::MODE_REWIND], mode_cnt[elog_pkg::MODE_SEARCH],
             mode_cnt[elog_pkg::MODE_CHANGE]);
    $display("%0d clear, %0d unused mode; write pointer wrapped %0d times; %0d mismatches",
             mode_cnt[elog_pkg::MODE_CLEAR], mode_cnt[MODE_SPARE_LO] + mode_cnt[MODE_SPARE_HI],
             wrap_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
